// File: rtl/ffeq_pkg.sv
// Shared constants, types and helpers for the flat-field frame equalizer.
`default_nettype none

package ffeq_pkg;

   localparam int MAX_WIDTH    = 1024;
   localparam int MAX_HEIGHT   = 512;
   localparam int COL_W        = $clog2(MAX_WIDTH);
   localparam int ROW_W        = $clog2(MAX_HEIGHT);
   localparam int ADDR_W       = COL_W + ROW_W;
   localparam int DEPTH        = MAX_WIDTH * MAX_HEIGHT;
   localparam int FW_W         = 11;
   localparam int FH_W         = 10;
   localparam int CSR_W        = 11;
   localparam int PIX_W        = 8;
   localparam int SUM_W        = 15;
   localparam int MIN_DIM      = 10;
   localparam int WIN_HALF     = 5;
   // sum / 100 as (sum * 5243) >> 19, exact for every 15-bit sum
   localparam int DIV_MUL_W    = 13;
   localparam int DIV_MUL      = 5243;
   localparam int DIV_SHIFT    = 19;
   localparam int PROD_W       = SUM_W + DIV_MUL_W;

   localparam logic [FW_W-1:0] RESET_WIDTH  = FW_W'(640);
   localparam logic [FH_W-1:0] RESET_HEIGHT = FH_W'(480);

   typedef enum logic [1:0] {
      ACT_PIXEL     = 2'd0,
      ACT_TOGGLE    = 2'd1,
      ACT_CALIBRATE = 2'd2
   } act_type;

   typedef enum logic {
      REG_FRAME_WIDTH  = 1'b0,
      REG_FRAME_HEIGHT = 1'b1
   } reg_type;

   function automatic logic [FW_W-1:0] clamp_width(input logic [FW_W-1:0] v);
      logic [FW_W-1:0] r;
      r = v;
      if (v < FW_W'(MIN_DIM)) r = FW_W'(MIN_DIM);
      else if (v > FW_W'(MAX_WIDTH)) r = FW_W'(MAX_WIDTH);
      return r;
   endfunction

   function automatic logic [FH_W-1:0] clamp_height(input logic [FH_W-1:0] v);
      logic [FH_W-1:0] r;
      r = v;
      if (v < FH_W'(MIN_DIM)) r = FH_W'(MIN_DIM);
      else if (v > FH_W'(MAX_HEIGHT)) r = FH_W'(MAX_HEIGHT);
      return r;
   endfunction

endpackage

`default_nettype wire

// File: rtl/flat_field_frame_equalizer_unit.sv
// Flat-field frame equalizer: reference frame store, window average, pixel correction.
//
//   channel | direction | beat contents
//   req_    | in        | tdata: pixel_in; tuser: action
//   rsp_    | out       | tdata: pixel_out; tlast: frame_end
//   csr_    | in        | write enable, register index, write data
//
// One beat per cycle unless clearing or a stalled result holds it; a pixel result is
// registered at the reference memory read, then after correction in the output register.
// After reset a clearing pass zeroes the 524288-entry reference memory, one entry
// a cycle; req_tready stays low until the pass ends, csr writes are taken. After that,
// a stalled result holds the correction stage; req_tready drops only when both are full.
`default_nettype none

module flat_field_frame_equalizer_unit (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_tvalid,
   output logic                              req_tready,
   input  wire logic [ffeq_pkg::PIX_W-1:0]   req_tdata,   // [7:0] pixel_in
   input  wire logic [1:0]                   req_tuser,   // [1:0] action
   output logic                              rsp_tvalid,
   input  wire logic                         rsp_tready,
   output logic [ffeq_pkg::PIX_W-1:0]        rsp_tdata,   // [7:0] pixel_out
   output logic                              rsp_tlast,
   input  wire logic                         csr_we,
   input  wire logic                         csr_index,
   input  wire logic [ffeq_pkg::CSR_W-1:0]   csr_wdata
);

   localparam int COL_W  = ffeq_pkg::COL_W;
   localparam int ROW_W  = ffeq_pkg::ROW_W;
   localparam int ADDR_W = ffeq_pkg::ADDR_W;
   localparam int PIX_W  = ffeq_pkg::PIX_W;
   localparam int SUM_W  = ffeq_pkg::SUM_W;
   localparam int FW_W   = ffeq_pkg::FW_W;
   localparam int FH_W   = ffeq_pkg::FH_W;

   logic [PIX_W-1:0] ref_mem [ffeq_pkg::DEPTH];

   logic [FW_W-1:0]   width_ff;
   logic [FH_W-1:0]   height_ff;
   logic [COL_W-1:0]  col_ff, col_in;
   logic [ROW_W-1:0]  row_ff, row_in;
   logic [SUM_W-1:0]  sum_ff, sum_in;
   logic [SUM_W-1:0]  sum_final_ff;
   logic              avg_pend_ff;
   logic [PIX_W-1:0]  avg_ff;
   logic              eq_ff, eq_in;
   logic              cal_ff, cal_in;
   logic              clr_busy_ff;
   logic [ADDR_W-1:0] clr_addr_ff;

   logic              s1_valid_ff;
   logic [PIX_W-1:0]  s1_pix_ff;
   logic              s1_eq_ff;
   logic              s1_last_ff;
   logic [PIX_W-1:0]  ref_rd_ff;

   logic              rsp_valid_ff;
   logic [PIX_W-1:0]  rsp_data_ff;
   logic              rsp_last_ff;

   ffeq_pkg::act_type act;
   logic              s1_go, s1_en, accept, pix_acc, cal_wr;
   logic              row_end, last, in_win;
   logic [COL_W-1:0]  cx, x_lo, x_hi;
   logic [ROW_W-1:0]  cy, y_lo, y_hi;
   logic [SUM_W-1:0]  sum_add;
   logic [ADDR_W-1:0] addr;
   logic [ffeq_pkg::PROD_W-1:0] prod;
   logic signed [PIX_W+1:0] diff;
   logic [PIX_W-1:0]  corr;

   assign s1_go      = !rsp_valid_ff || rsp_tready;
   assign s1_en      = !s1_valid_ff || s1_go;
   assign req_tready = !clr_busy_ff && s1_en;
   assign accept     = req_tvalid && req_tready;
   assign act        = ffeq_pkg::act_type'(req_tuser);
   assign pix_acc    = accept && (act == ffeq_pkg::ACT_PIXEL);
   assign cal_wr     = pix_acc && cal_ff && !eq_ff;

   assign row_end = {1'b0, col_ff} >= (width_ff - FW_W'(1));
   assign last    = row_end && ({1'b0, row_ff} >= (height_ff - FH_W'(1)));
   assign cx      = width_ff[COL_W:1];
   assign cy      = height_ff[ROW_W:1];
   assign x_lo    = cx - COL_W'(ffeq_pkg::WIN_HALF);
   assign x_hi    = cx + COL_W'(ffeq_pkg::WIN_HALF);
   assign y_lo    = cy - ROW_W'(ffeq_pkg::WIN_HALF);
   assign y_hi    = cy + ROW_W'(ffeq_pkg::WIN_HALF);
   assign in_win  = (col_ff >= x_lo) && (col_ff < x_hi) && (row_ff >= y_lo) && (row_ff < y_hi);
   assign sum_add = in_win ? sum_ff + SUM_W'(req_tdata) : sum_ff;
   assign addr    = {row_ff, col_ff};
   assign prod    = sum_final_ff * ffeq_pkg::DIV_MUL_W'(ffeq_pkg::DIV_MUL);

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      sum_in = sum_ff;
      eq_in  = eq_ff;
      cal_in = cal_ff;
      if (accept) begin
         unique case (act)
            ffeq_pkg::ACT_TOGGLE: begin
               eq_in  = !eq_ff;
               cal_in = 1'b0;
               col_in = '0;
               row_in = '0;
               sum_in = '0;
            end
            ffeq_pkg::ACT_CALIBRATE: begin
               eq_in  = 1'b0;
               cal_in = 1'b1;
               col_in = '0;
               row_in = '0;
               sum_in = '0;
            end
            ffeq_pkg::ACT_PIXEL: begin
               if (cal_wr) begin
                  sum_in = sum_add;
                  if (last) begin
                     cal_in = 1'b0;
                     eq_in  = 1'b1;
                  end
               end
               if (last) begin
                  col_in = '0;
                  row_in = '0;
                  sum_in = '0;
               end else if (row_end) begin
                  col_in = '0;
                  row_in = row_ff + ROW_W'(1);
               end else begin
                  col_in = col_ff + COL_W'(1);
               end
            end
            default: ;
         endcase
      end
      if (csr_we) begin
         col_in = '0;
         row_in = '0;
         sum_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff     <= ffeq_pkg::RESET_WIDTH;
         height_ff    <= ffeq_pkg::RESET_HEIGHT;
         col_ff       <= '0;
         row_ff       <= '0;
         sum_ff       <= '0;
         avg_pend_ff  <= 1'b0;
         avg_ff       <= '0;
         eq_ff        <= 1'b0;
         cal_ff       <= 1'b0;
         clr_busy_ff  <= 1'b1;
         clr_addr_ff  <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
         sum_ff <= sum_in;
         eq_ff  <= eq_in;
         cal_ff <= cal_in;
         if (csr_we) begin
            unique case (ffeq_pkg::reg_type'(csr_index))
               ffeq_pkg::REG_FRAME_WIDTH:  width_ff  <= ffeq_pkg::clamp_width(csr_wdata);
               ffeq_pkg::REG_FRAME_HEIGHT: height_ff <= ffeq_pkg::clamp_height(csr_wdata[FH_W-1:0]);
               default: ;
            endcase
         end
         avg_pend_ff <= cal_wr && last;
         if (avg_pend_ff) avg_ff <= prod[ffeq_pkg::DIV_SHIFT +: PIX_W];
         if (clr_busy_ff) begin
            clr_addr_ff <= clr_addr_ff + ADDR_W'(1);
            if (&clr_addr_ff) clr_busy_ff <= 1'b0;
         end
         if (s1_en) s1_valid_ff <= pix_acc;
         if (s1_go) rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cal_wr && last) sum_final_ff <= sum_add;
      if (pix_acc) begin
         s1_pix_ff  <= req_tdata;
         s1_eq_ff   <= eq_ff;
         s1_last_ff <= last;
      end
      if (s1_go) begin
         rsp_data_ff <= s1_eq_ff ? corr : s1_pix_ff;
         rsp_last_ff <= s1_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (clr_busy_ff) ref_mem[clr_addr_ff] <= '0;
      else if (cal_wr) ref_mem[addr] <= req_tdata;
      if (pix_acc) ref_rd_ff <= ref_mem[addr];
   end

   always_comb begin
      diff = $signed({2'b00, s1_pix_ff}) + $signed({2'b00, avg_ff})
           - $signed({2'b00, ref_rd_ff});
      if (diff[PIX_W+1]) corr = '0;
      else if (diff[PIX_W]) corr = '1;
      else corr = diff[PIX_W-1:0];
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

`default_nettype wire
